>>> sv/uniform_table_linear_interpolator_assert.svh
// Assertion macros shared by the interpolator RTL.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef UNIFORM_TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define UNIFORM_TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define UTLI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define UTLI_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/utli_pkg.sv
// Shared types and constants for the uniform table linear interpolator.
// No dependencies; used by every module of the block.
`default_nettype none

package utli_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned INDEX_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN         = 2'd0,
    REG_SPACING_SHIFT  = 2'd1,
    REG_ENTRIES_IN_USE = 2'd2
  } cfg_reg_t;

  // Control bits that travel with an item through the address stage.
  typedef struct packed {
    logic valid;
    logic query;
    logic wr;
  } ctrl_t;

  // Interpolation weights: y = (s1*rel + s0*w0 + 2^(sh-1)) >>> sh.
  typedef struct packed {
    logic [DATA_W-1:0]  rel;
    logic [DATA_W-1:0]  w0;
    logic [SHIFT_W-1:0] sh;
  } weight_t;

endpackage

`default_nettype wire

>>> sv/utli_addr_stage.sv
// Offset and index decode stages (A and B) of the interpolator pipeline.
// Depends on utli_pkg and the assertion macro header.
`default_nettype none
`include "uniform_table_linear_interpolator_assert.svh"

module utli_addr_stage #(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   en,
  input  wire                                   in_valid,
  input  wire                                   mode,
  input  wire        [utli_pkg::INDEX_W-1:0]    entry_index,
  input  wire signed [utli_pkg::DATA_W-1:0]     entry_value,
  input  wire signed [utli_pkg::DATA_W-1:0]     x,
  input  wire signed [utli_pkg::DATA_W-1:0]     origin,
  input  wire        [utli_pkg::SHIFT_W-1:0]    spacing_shift,
  input  wire        [utli_pkg::COUNT_W-1:0]    entries_in_use,
  output utli_pkg::ctrl_t                       b_ctrl,
  output logic       [AW-1:0]                   b_addr0,
  output logic       [AW-1:0]                   b_addr1,
  output logic signed [utli_pkg::DATA_W-1:0]    b_wdata,
  output utli_pkg::weight_t                     b_weight
);

  // Stage A registers.
  logic                              a_valid;
  logic                              a_query;
  logic [utli_pkg::INDEX_W-1:0]      a_index;
  logic signed [utli_pkg::DATA_W-1:0] a_value;
  logic signed [utli_pkg::DATA_W:0]  a_dx;

  // Stage B combinational decode.
  logic signed [utli_pkg::DATA_W:0]  idx;
  logic [31:0]                       n_lim;
  logic [AW-1:0]                     last;
  logic [utli_pkg::DATA_W-1:0]       x1;
  logic [utli_pkg::DATA_W-1:0]       rel;
  logic                              at_top;
  logic                              wr_ok;
  utli_pkg::ctrl_t                   ctrl_next;
  utli_pkg::weight_t                 weight_next;
  logic [AW-1:0]                     addr0_next;
  logic [AW-1:0]                     addr1_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  // The offset is formed at 33 bits so that it never wraps.
  always_ff @(posedge clk) begin
    if (en) begin
      a_query <= (mode == utli_pkg::MODE_QUERY);
      a_index <= entry_index;
      a_value <= entry_value;
      a_dx    <= 33'(x) - 33'(origin);
    end
  end

  always_comb begin
    n_lim = 32'(entries_in_use);
    if (n_lim < 32'd1) begin
      n_lim = 32'd1;
    end
    if (n_lim > 32'(DEPTH)) begin
      n_lim = 32'(DEPTH);
    end
    last = AW'(n_lim - 32'd1);

    idx    = a_dx >>> spacing_shift;
    x1     = 32'd1 << spacing_shift;
    rel    = a_dx[utli_pkg::DATA_W-1:0] & (x1 - 32'd1);
    at_top = (idx[utli_pkg::DATA_W-1:0] >= 32'(last));
    wr_ok  = (32'(a_index) < 32'(DEPTH));

    weight_next.sh  = spacing_shift;
    weight_next.rel = '0;
    weight_next.w0  = x1;

    // Clamped queries read one entry with full weight, which rounds back to it.
    if (!a_query) begin
      addr0_next = AW'(a_index);
      addr1_next = AW'(a_index);
    end else if (idx[utli_pkg::DATA_W]) begin
      addr0_next = '0;
      addr1_next = '0;
    end else if (at_top) begin
      addr0_next = last;
      addr1_next = last;
    end else begin
      addr0_next      = AW'(idx[utli_pkg::DATA_W-1:0]);
      addr1_next      = AW'(idx[utli_pkg::DATA_W-1:0]) + AW'(1);
      weight_next.rel = rel;
      weight_next.w0  = x1 - rel;
    end

    ctrl_next.valid = a_valid;
    ctrl_next.query = a_valid && a_query;
    ctrl_next.wr    = a_valid && !a_query && wr_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_ctrl <= '0;
    end else if (en) begin
      b_ctrl <= ctrl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_addr0  <= addr0_next;
      b_addr1  <= addr1_next;
      b_wdata  <= a_value;
      b_weight <= weight_next;
    end
  end

  `UTLI_ASSERT_IMP(a_weight_sum, clk, rst, b_ctrl.query,
    (33'(b_weight.rel) + 33'(b_weight.w0)) == (33'd1 << b_weight.sh),
    "interpolation weights do not add up to one spacing")
  `UTLI_ASSERT_IMP(a_addr_in_use, clk, rst, b_ctrl.query,
    32'(b_addr0) < 32'(DEPTH) && 32'(b_addr1) < 32'(DEPTH),
    "query address beyond the table")
  `UTLI_ASSERT_IMP(a_neighbors, clk, rst, b_ctrl.query && b_weight.rel != '0,
    b_addr1 == b_addr0 + AW'(1),
    "interior query does not read neighboring entries")

endmodule

`default_nettype wire

>>> sv/utli_sample_mem.sv
// Sample table memory and stage C: one write port, two registered read ports.
// Depends on utli_pkg.
`default_nettype none

module utli_sample_mem #(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   en,
  input  wire utli_pkg::ctrl_t                  b_ctrl,
  input  wire        [AW-1:0]                   b_addr0,
  input  wire        [AW-1:0]                   b_addr1,
  input  wire signed [utli_pkg::DATA_W-1:0]     b_wdata,
  input  wire utli_pkg::weight_t                b_weight,
  output logic                                  c_valid,
  output logic signed [utli_pkg::DATA_W-1:0]    c_s0,
  output logic signed [utli_pkg::DATA_W-1:0]    c_s1,
  output utli_pkg::weight_t                     c_weight
);

  logic [utli_pkg::DATA_W-1:0] mem [DEPTH];

  // Writes and reads happen in the same stage, so items see the table in order.
  always_ff @(posedge clk) begin
    if (en && b_ctrl.wr) begin
      mem[b_addr0] <= b_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_s0     <= mem[b_addr0];
      c_s1     <= mem[b_addr1];
      c_weight <= b_weight;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_ctrl.query;
    end
  end

endmodule

`default_nettype wire

>>> sv/utli_mac.sv
// Weighted sum stages D and E and the output register F.
// Depends on utli_pkg.
`default_nettype none

module utli_mac (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   en,
  input  wire                                   c_valid,
  input  wire signed [utli_pkg::DATA_W-1:0]     c_s0,
  input  wire signed [utli_pkg::DATA_W-1:0]     c_s1,
  input  wire utli_pkg::weight_t                c_weight,
  output logic                                  out_valid,
  output logic signed [utli_pkg::DATA_W-1:0]    y
);

  logic signed [utli_pkg::DATA_W:0]     rel_s;
  logic signed [utli_pkg::DATA_W:0]     w0_s;
  logic signed [2*utli_pkg::DATA_W:0]   prod0;
  logic signed [2*utli_pkg::DATA_W:0]   prod1;

  logic                                 d_valid;
  logic signed [2*utli_pkg::DATA_W-1:0] d_p0;
  logic signed [2*utli_pkg::DATA_W-1:0] d_p1;
  logic [utli_pkg::DATA_W-1:0]          d_half;
  logic [utli_pkg::SHIFT_W-1:0]         d_sh;

  logic                                 e_valid;
  logic signed [2*utli_pkg::DATA_W-1:0] e_acc;
  logic [utli_pkg::SHIFT_W-1:0]         e_sh;
  logic signed [2*utli_pkg::DATA_W-1:0] shifted;

  always_comb begin
    rel_s   = $signed({1'b0, c_weight.rel});
    w0_s    = $signed({1'b0, c_weight.w0});
    prod0   = c_s0 * w0_s;
    prod1   = c_s1 * rel_s;
    shifted = e_acc >>> e_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      d_valid   <= c_valid;
      e_valid   <= d_valid;
      out_valid <= e_valid;
    end
  end

  // The sum of both products stays within 63 bits, so the 64-bit accumulator cannot overflow.
  always_ff @(posedge clk) begin
    if (en) begin
      d_p0   <= prod0[2*utli_pkg::DATA_W-1:0];
      d_p1   <= prod1[2*utli_pkg::DATA_W-1:0];
      d_half <= (32'd1 << c_weight.sh) >> 1;
      d_sh   <= c_weight.sh;
      e_acc  <= d_p0 + d_p1 + 64'(d_half);
      e_sh   <= d_sh;
      y      <= shifted[utli_pkg::DATA_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> sv/uniform_table_linear_interpolator.sv
// Uniform table linear interpolator, top level: configuration registers and pipeline.
// A query passes through stages A to E and the output register F before its result is valid.
// Throughput: one transaction per cycle; the whole pipeline holds while a result is stalled.
// Write transactions update the sample table in the memory stage and give no result.
// Reset clears the pipeline valid bits and sets origin 0, spacing shift 0, two entries.
// The sample table is not cleared; entries must be written before they are queried.
`default_nettype none
`include "uniform_table_linear_interpolator_assert.svh"

module uniform_table_linear_interpolator #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_wr_en,
  input  wire        [utli_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire        [utli_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire                                   mode,
  input  wire        [utli_pkg::INDEX_W-1:0]    entry_index,
  input  wire signed [utli_pkg::DATA_W-1:0]     entry_value,
  input  wire signed [utli_pkg::DATA_W-1:0]     x,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [utli_pkg::DATA_W-1:0]    y
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic signed [utli_pkg::DATA_W-1:0]  origin;
  logic [utli_pkg::SHIFT_W-1:0]        spacing_shift;
  logic [utli_pkg::COUNT_W-1:0]        entries_in_use;

  logic                                en;
  utli_pkg::ctrl_t                     b_ctrl;
  logic [AW-1:0]                       b_addr0;
  logic [AW-1:0]                       b_addr1;
  logic signed [utli_pkg::DATA_W-1:0]  b_wdata;
  utli_pkg::weight_t                   b_weight;
  logic                                c_valid;
  logic signed [utli_pkg::DATA_W-1:0]  c_s0;
  logic signed [utli_pkg::DATA_W-1:0]  c_s1;
  utli_pkg::weight_t                   c_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin         <= '0;
      spacing_shift  <= '0;
      entries_in_use <= 9'd2;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        utli_pkg::REG_ORIGIN:         origin         <= cfg_data;
        utli_pkg::REG_SPACING_SHIFT:  spacing_shift  <= cfg_data[utli_pkg::SHIFT_W-1:0];
        utli_pkg::REG_ENTRIES_IN_USE: entries_in_use <= cfg_data[utli_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline advances unless a finished result is waiting at the output.
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  utli_addr_stage #(
    .DEPTH (TABLE_DEPTH)
  ) u_addr (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (in_valid),
    .mode           (mode),
    .entry_index    (entry_index),
    .entry_value    (entry_value),
    .x              (x),
    .origin         (origin),
    .spacing_shift  (spacing_shift),
    .entries_in_use (entries_in_use),
    .b_ctrl         (b_ctrl),
    .b_addr0        (b_addr0),
    .b_addr1        (b_addr1),
    .b_wdata        (b_wdata),
    .b_weight       (b_weight)
  );

  utli_sample_mem #(
    .DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .b_ctrl   (b_ctrl),
    .b_addr0  (b_addr0),
    .b_addr1  (b_addr1),
    .b_wdata  (b_wdata),
    .b_weight (b_weight),
    .c_valid  (c_valid),
    .c_s0     (c_s0),
    .c_s1     (c_s1),
    .c_weight (c_weight)
  );

  utli_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .c_valid   (c_valid),
    .c_s0      (c_s0),
    .c_s1      (c_s1),
    .c_weight  (c_weight),
    .out_valid (out_valid),
    .y         (y)
  );

  `UTLI_ASSERT_IMP(a_hold_on_stall, clk, rst, out_valid && out_stall, in_stall,
    "input taken while a result is stalled")
  `UTLI_ASSERT_NXT(a_query_to_mem, clk, rst, en && b_ctrl.query, c_valid,
    "query lost between address and memory stage")
  `UTLI_ASSERT_NXT(a_write_silent, clk, rst, en && b_ctrl.valid && !b_ctrl.query, !c_valid,
    "table write produced a result")

endmodule

`default_nettype wire

>>> dv/tb_uniform_table_linear_interpolator.sv
// Self-checking testbench for uniform_table_linear_interpolator: a directed table, then random phases.
// Depends on utli_pkg and the interpolator RTL; expected values come from an in-bench predictor or typed-in rows.
`default_nettype none

module tb_uniform_table_linear_interpolator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH     = 256;
  localparam int PIPE_LATENCY    = 5;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int PAUSE_PHASE     = 2;
  localparam int QUIET_PHASE     = 5;
  localparam int HOLD_AT_ITEM    = 700;
  localparam int HOLD_CYCLES     = 80;
  localparam int WATCHDOG_LIMIT  = 2000;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_WRITE,
    ROW_QUERY
  } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    utli_pkg::cfg_reg_t   reg_sel;
    logic [31:0]          data;
    logic [7:0]           index;
    logic [31:0]          xq;
    logic                 typed;
    logic [31:0]          y_typed;
  } step_row_t;

  localparam int N_DIRECTED = 33;

  // Expected values are typed in only where they follow directly from the entries.
  step_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_WRITE, utli_pkg::REG_ORIGIN, 32'h7fff_ffff, 8'd0, 32'h0, 1'b0, 32'h0},
    '{ROW_WRITE, utli_pkg::REG_ORIGIN, 32'h8000_0000, 8'd1, 32'h0, 1'b0, 32'h0},
    '{ROW_WRITE, utli_pkg::REG_ORIGIN, 32'hffff_fffb, 8'd2, 32'h0, 1'b0, 32'h0},
    '{ROW_WRITE, utli_pkg::REG_ORIGIN, 32'hffff_fffc, 8'd3, 32'h0, 1'b0, 32'h0},
    '{ROW_WRITE, utli_pkg::REG_ORIGIN, 32'h1234_5678, 8'd255, 32'h0, 1'b0, 32'h0},
    // Reset settings: origin 0, unit spacing, two entries.
    '{ROW_QUERY, utli_pkg::REG_ORIGIN, 32'h0, 8'd0, 32'hffff_ffff, 1'b1, 32'h7fff_ffff},
    '{ROW_QUERY, utli_pkg::REG_ORIGIN, 32'h0, 8'd0, 32'h0000_0000, 1'b1, 32'h7fff_ffff},
    '{ROW_QUERY, utli_pkg::REG_ORIGIN, 32'h0, 8'd0, 32'h0000_0001, 1'b1, 32'h8000_0000},
    '{ROW_QUERY, utli_pkg::REG_ORIGIN, 32'h0, 8'd0, 32'h7fff_ffff, 1'b1, 32'h8000_0000},
    '{ROW_QUERY, utli_pkg::REG_ORIGIN, 32'h0, 8'd0, 32'h8000_0000, 1'b1, 32'h7fff_ffff},
    // A 32-bit offset would wrap to +1 here; the 33-bit offset is negative.
    '{ROW_CFG, utli_pkg::REG_ORIGIN, 32'h7fff_ffff, 8'd0, 32'h0, 1'b0, 32'h0},
    '{ROW_QUERY, utli_pkg::REG_ORIGIN, 32'h0, 8'd0, 32'h8000_0000, 1'b1, 32'h7fff_ffff},
    '{ROW_QUERY, utli_pkg::REG_ORIGIN, 32'h0, 8'd0, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff},
    // Shift of 31 with the full table and the lowest origin.
    '{ROW_CFG, utli_pkg::REG_SPACING_SHIFT, 32'd31, 8'd0, 32'h0, 1'b0, 32'h0},
    '{ROW_CFG, utli_pkg::REG_ENTRIES_IN_USE, 32'd256, 8'd0, 32'h0, 1'b0, 32'h0},
    '{ROW_CFG, utli_pkg::REG_ORIGIN, 32'h8000_0000, 8'd0, 32'h0, 1'b0, 32'h0},
    '{ROW_QUERY, utli_pkg::REG_ORIGIN, 32'h0, 8'd0, 32'h8000_0000, 1'b1, 32'h7fff_ffff},
    '{ROW_QUERY, utli_pkg::REG_ORIGIN, 32'h0, 8'd0, 32'h7fff_ffff, 1'b0, 32'h0},
    '{ROW_QUERY, utli_pkg::REG_ORIGIN, 32'h0, 8'd0, 32'hffff_ffff, 1'b0, 32'h0},
    // Entry counts beyond the table act as the table depth.
    '{ROW_CFG, utli_pkg::REG_SPACING_SHIFT, 32'd0, 8'd0, 32'h0, 1'b0, 32'h0},
    '{ROW_CFG, utli_pkg::REG_ENTRIES_IN_USE, 32'd511, 8'd0, 32'h0, 1'b0, 32'h0},
    '{ROW_QUERY, utli_pkg::REG_ORIGIN, 32'h0, 8'd0, 32'h7fff_ffff, 1'b1, 32'h1234_5678},
    // Entry counts of zero and one leave only entry 0.
    '{ROW_CFG, utli_pkg::REG_ENTRIES_IN_USE, 32'd0, 8'd0, 32'h0, 1'b0, 32'h0},
    '{ROW_QUERY, utli_pkg::REG_ORIGIN, 32'h0, 8'd0, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff},
    '{ROW_CFG, utli_pkg::REG_ENTRIES_IN_USE, 32'd1, 8'd0, 32'h0, 1'b0, 32'h0},
    '{ROW_QUERY, utli_pkg::REG_ORIGIN, 32'h0, 8'd0, 32'h0000_0000, 1'b1, 32'h7fff_ffff},
    // Halfway between -5 and -4 rounds up to -4; the grid point gives -5.
    '{ROW_CFG, utli_pkg::REG_ORIGIN, 32'h0, 8'd0, 32'h0, 1'b0, 32'h0},
    '{ROW_CFG, utli_pkg::REG_SPACING_SHIFT, 32'd1, 8'd0, 32'h0, 1'b0, 32'h0},
    '{ROW_CFG, utli_pkg::REG_ENTRIES_IN_USE, 32'd256, 8'd0, 32'h0, 1'b0, 32'h0},
    '{ROW_QUERY, utli_pkg::REG_ORIGIN, 32'h0, 8'd0, 32'h0000_0005, 1'b1, 32'hffff_fffc},
    '{ROW_QUERY, utli_pkg::REG_ORIGIN, 32'h0, 8'd0, 32'h0000_0004, 1'b1, 32'hffff_fffb},
    '{ROW_QUERY, utli_pkg::REG_ORIGIN, 32'h0, 8'd0, 32'h0000_0003, 1'b0, 32'h0},
    '{ROW_QUERY, utli_pkg::REG_ORIGIN, 32'h0, 8'd0, 32'h0000_0001, 1'b0, 32'h0}
  };

  logic                            clk;
  logic                            rst;
  logic                            cfg_wr_en;
  logic [utli_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [utli_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic                            mode;
  logic [utli_pkg::INDEX_W-1:0]    entry_index;
  logic signed [31:0]              entry_value;
  logic signed [31:0]              x;
  logic                            out_valid;
  logic                            out_stall;
  logic signed [31:0]              y;

  // Predictor state: a mirror of the sample table and the configuration registers.
  logic signed [31:0] sample_mirror [TABLE_DEPTH];
  logic signed [31:0] origin_shadow;
  logic [4:0]         shift_shadow;
  logic [8:0]         count_shadow;
  logic [31:0]        expected_y_q [$];

  bit quiet_mode;
  int items_sent;
  int writes_sent;
  int queries_sent;
  int results_checked;
  int reg_writes;
  int mismatch_count;
  int stuck_cycles = 0;

  uniform_table_linear_interpolator #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .x           (x),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .y           (y)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int live_entries();
    if (count_shadow < 9'd1) return 1;
    if (count_shadow > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(count_shadow);
  endfunction

  function automatic logic [31:0] predict_y(logic signed [31:0] xq);
    longint offset;
    longint seg;
    longint span;
    longint frac;
    longint lo;
    longint hi;
    longint acc;
    int     n;
    n      = live_entries();
    offset = longint'(xq) - longint'(origin_shadow);
    seg    = offset >>> shift_shadow;
    if (seg < 0) begin
      acc = longint'(sample_mirror[0]);
    end else if (seg >= n - 1) begin
      acc = longint'(sample_mirror[n - 1]);
    end else begin
      span = longint'(1) <<< shift_shadow;
      frac = offset & (span - 1);
      lo   = longint'(sample_mirror[seg]);
      hi   = longint'(sample_mirror[seg + 1]);
      acc  = (hi * frac + lo * (span - frac) + (span >>> 1)) >>> shift_shadow;
    end
    return acc[31:0];
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Most query points land on, inside or just beside the table's intervals.
  function automatic logic [31:0] pick_query_x();
    longint span;
    longint target;
    int     sel;
    span   = longint'(1) <<< shift_shadow;
    sel    = $urandom_range(9);
    target = longint'(origin_shadow) + longint'($urandom_range(live_entries())) * span;
    if (sel == 0) return $urandom;
    if (sel == 1) target = target - longint'($urandom_range(3));
    else if (sel == 2) target = target + (span >>> 1);
    else if (sel >= 4) target = target + (longint'($urandom) & (span - 1));
    if (target < -64'sd2147483648 || target > 64'sd2147483647) return $urandom;
    return target[31:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Called right after a falling edge; returns right after the falling edge that
  // follows the accepting rising edge.
  task automatic send_item(logic m, logic [7:0] idx, logic [31:0] val, logic [31:0] xv,
                           logic use_typed, logic [31:0] y_typed);
    while (!quiet_mode && $urandom_range(99) < 15) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    mode        = m;
    entry_index = idx;
    entry_value = val;
    x           = xv;
    do @(posedge clk); while (in_stall);
    if (m == utli_pkg::MODE_WRITE) begin
      sample_mirror[idx] = val;
      writes_sent++;
    end else begin
      expected_y_q.push_back(use_typed ? y_typed : predict_y(xv));
      queries_sent++;
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    while (expected_y_q.size() != 0) @(negedge clk);
  endtask

  // Writes leave no result behind, so the pipeline gets its latency to empty as well.
  task automatic settle_before_config();
    in_valid = 1'b0;
    wait_results_drained();
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_register(utli_pkg::cfg_reg_t sel, logic [31:0] value);
    cfg_wr_en = 1'b1;
    cfg_index = sel;
    cfg_data  = value;
    @(posedge clk);
    case (sel)
      utli_pkg::REG_ORIGIN:         origin_shadow = value;
      utli_pkg::REG_SPACING_SHIFT:  shift_shadow  = value[4:0];
      utli_pkg::REG_ENTRIES_IN_USE: count_shadow  = value[8:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    @(negedge clk);
  endtask

  // Output side: random stalls, plus one long hold that backs up the pipeline.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
        hold_done = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall = !quiet_mode && ($urandom_range(99) < 15);
    end
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_y_q.size() == 0) begin
        report_mismatch($sformatf("result y=%h arrived with nothing expected", y));
      end else begin
        want = expected_y_q.pop_front();
        results_checked++;
        if (y !== want) report_mismatch($sformatf("y got %h expected %h", y, want));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    logic [31:0] org;
    logic [31:0] shf;
    logic [31:0] cnt;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_index     = utli_pkg::REG_ORIGIN;
    cfg_data      = '0;
    in_valid      = 1'b0;
    mode          = utli_pkg::MODE_WRITE;
    entry_index   = '0;
    entry_value   = '0;
    x             = '0;
    quiet_mode    = 1'b0;
    origin_shadow = '0;
    shift_shadow  = '0;
    count_shadow  = 9'd2;
    foreach (sample_mirror[i]) sample_mirror[i] = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < N_DIRECTED; r++) begin
      case (directed_rows[r].kind)
        ROW_CFG: begin
          settle_before_config();
          write_register(directed_rows[r].reg_sel, directed_rows[r].data);
        end
        ROW_WRITE: send_item(utli_pkg::MODE_WRITE, directed_rows[r].index,
                             directed_rows[r].data, $urandom, 1'b0, 32'h0);
        default:   send_item(utli_pkg::MODE_QUERY, 8'($urandom_range(255)), $urandom,
                             directed_rows[r].xq, directed_rows[r].typed,
                             directed_rows[r].y_typed);
      endcase
    end

    // Fill the whole table so that every later query reads written entries.
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      send_item(utli_pkg::MODE_WRITE, k[7:0], rand_sample(), $urandom, 1'b0, 32'h0);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      settle_before_config();
      case (p)
        0: begin
          org = 32'h8000_0000;
          shf = 30;
          cnt = 256;
        end
        1: begin
          org = 32'h7fff_ffff;
          shf = 0;
          cnt = 2;
        end
        default: begin
          case ($urandom_range(4))
            0:       org = 32'h8000_0000;
            1:       org = 32'h7fff_ffff;
            2:       org = $urandom;
            default: org = $urandom_range(2000) - 1000;
          endcase
          case ($urandom_range(5))
            0:       shf = 31;
            1:       shf = 30;
            2:       shf = $urandom_range(4);
            default: shf = $urandom_range(30);
          endcase
          case ($urandom_range(6))
            0:       cnt = $urandom_range(1);
            1:       cnt = $urandom_range(511, 257);
            2:       cnt = 256;
            3:       cnt = $urandom_range(8, 2);
            default: cnt = $urandom_range(256, 2);
          endcase
        end
      endcase
      write_register(utli_pkg::REG_ORIGIN, org);
      write_register(utli_pkg::REG_SPACING_SHIFT, shf);
      write_register(utli_pkg::REG_ENTRIES_IN_USE, cnt);
      quiet_mode = (p == QUIET_PHASE);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == PAUSE_PHASE && i == ITEMS_PER_PHASE / 2) begin
          in_valid = 1'b0;
          wait_results_drained();
        end
        if ($urandom_range(99) < 20) begin
          send_item(utli_pkg::MODE_WRITE, 8'($urandom_range(255)), rand_sample(), $urandom,
                    1'b0, 32'h0);
        end else begin
          send_item(utli_pkg::MODE_QUERY, 8'($urandom_range(255)), $urandom, pick_query_x(),
                    1'b0, 32'h0);
        end
      end
    end

    in_valid   = 1'b0;
    quiet_mode = 1'b0;
    wait_results_drained();
    repeat (2 * PIPE_LATENCY) @(posedge clk);

    $display("Sent %0d table writes and %0d queries; %0d results checked; %0d register writes.",
             writes_sent, queries_sent, results_checked, reg_writes);
    $display("Settings spanned extreme origins, shifts 0 to 31 and clamped entry counts.");
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
